// File: sv/smx_pkg.sv
// smx_pkg: shared constants for the stack machine execution unit
// no dependencies; used by the interfaces, the divider and the top level
`default_nettype none

package smx_pkg;

  // data path and stack geometry
  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMD_W       = 4;
  localparam int STAT_W      = 2;

  // divider iteration counter
  localparam int DIV_CNT_W = $clog2(DATA_W);

  // command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN = 4'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_ADD   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SUB   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_MUL   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DIV   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_OUT   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_IN    = 4'd9;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DIVZ  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OVER  = 2'd3;

endpackage

`default_nettype wire

// File: sv/smx_if.sv
// smx_in_if / smx_out_if: valid-ready channels for instruction and result words
// depends on smx_pkg for field widths
`default_nettype none

interface smx_in_if import smx_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink   (input valid, input cmd, input operand, output ready);
endinterface

interface smx_out_if import smx_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_valid;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         depth;

  modport source (output valid, output out_value, output out_valid, output status,
                  output depth, input ready);
  modport sink   (input valid, input out_value, input out_valid, input status,
                  input depth, output ready);
endinterface

`default_nettype wire

// File: sv/smx_ram.sv
// smx_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/smx_div.sv
// smx_div: signed 32-bit divider, truncating toward zero, one quotient bit per cycle
// depends on smx_pkg
`default_nettype none

module smx_div import smx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] a_i,
  input  wire logic [DATA_W-1:0] b_i,
  output logic                   done_o,
  output logic      [DATA_W-1:0] q_o
);

  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DATA_W-1:0]    den_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DATA_W:0]      trial;
  logic [DATA_W-1:0]    mag_a;
  logic [DATA_W-1:0]    mag_b;

  // operand magnitudes
  assign mag_a = a_i[DATA_W-1] ? (DATA_W'(0) - a_i) : a_i;
  assign mag_b = b_i[DATA_W-1] ? (DATA_W'(0) - b_i) : b_i;

  // trial subtract of the shifted partial remainder
  assign trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, den_r};

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DATA_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring shift-subtract on magnitudes
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      quo_r <= mag_a;
      den_r <= mag_b;
      neg_r <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
    end else if (busy_r) begin
      if (!trial[DATA_W]) begin
        rem_r <= trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  // sign fix of the quotient
  assign q_o    = neg_r ? (DATA_W'(0) - quo_r) : quo_r;
  assign done_o = done_r;

endmodule

`default_nettype wire

// File: sv/stack_machine_execute.sv
// stack_machine_execute: one stack-machine instruction per input word, one result word each
// depends on smx_pkg, smx_if (channels), smx_ram (stack store) and smx_div (divider)
`default_nettype none

// The stack top is held in a register and the entries below it live in a
// 256-word stack RAM with registered read data, so every instruction
// needs at most one RAM read. The result word (status, depth and the value
// popped by out) is loaded into the output register the cycle the
// instruction is accepted; the next instruction is taken once the sequencer
// is back in idle and that register is free or being drained. Push, in,
// no-ops and any error case other than divide by zero finish on acceptance;
// pop and out refill the top register with a RAM read when the stack is not
// left empty; add, sub and mul read the second operand from RAM, then run
// the ALU; divide by zero refills the top when needed; div reads the second
// operand, then starts the divider and waits for it to finish. No clearing
// pass is needed after reset.
module stack_machine_execute import smx_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  smx_in_if.sink   in_ch,
  smx_out_if.source out_ch
);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REFILL = 2'd1;
  localparam logic [1:0] S_ALU    = 2'd2;
  localparam logic [1:0] S_DIV    = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [DATA_W-1:0]   top_r, top_nxt;
  logic [CMD_W-1:0]    op_r, op_nxt;
  logic                ov_r, ov_nxt;
  logic [DATA_W-1:0]   oval_r, oval_nxt;
  logic                ovld_r, ovld_nxt;
  logic [STAT_W-1:0]   ostat_r, ostat_nxt;
  logic [CNT_W-1:0]    odepth_r, odepth_nxt;

  logic                acc;
  logic                ram_we;
  logic [SP_W-1:0]     ram_waddr;
  logic [SP_W-1:0]     ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;
  logic [CNT_W-1:0]    below_cnt;
  logic [CNT_W-1:0]    rd_idx;
  logic [2*DATA_W-1:0] prod;
  logic                div_start;
  logic                div_done;
  logic [DATA_W-1:0]   div_q;
  logic                full;

  assign in_ch.ready = (state_r == S_IDLE) && (!ov_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(STACK_DEPTH));

  // addresses: the old top spills to count-1, refills come from new count-1
  assign below_cnt = count_r - CNT_W'(1);
  assign ram_waddr = below_cnt[SP_W-1:0];
  assign rd_idx    = count_nxt - CNT_W'(1);
  assign ram_raddr = rd_idx[SP_W-1:0];

  assign prod = ram_rdata * top_r;

  // instruction sequencing
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    op_nxt     = op_r;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    ov_nxt     = ov_r && !out_ch.ready;
    oval_nxt   = oval_r;
    ovld_nxt   = ovld_r;
    ostat_nxt  = ostat_r;
    odepth_nxt = odepth_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          ov_nxt    = 1'b1;
          oval_nxt  = '0;
          ovld_nxt  = 1'b0;
          ostat_nxt = STAT_OK;
          case (in_ch.cmd)
            CMD_PUSH, CMD_IN: begin
              if (full) begin
                ostat_nxt = STAT_OVER;
              end else begin
                ram_we    = (count_r != '0);
                top_nxt   = in_ch.operand;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_POP, CMD_OUT: begin
              if (count_r == '0) begin
                ostat_nxt = STAT_UNDER;
              end else begin
                count_nxt = below_cnt;
                if (in_ch.cmd == CMD_OUT) begin
                  oval_nxt = top_r;
                  ovld_nxt = 1'b1;
                end
                if (count_r >= CNT_W'(2)) begin
                  state_nxt = S_REFILL;
                end
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (count_r < CNT_W'(2)) begin
                ostat_nxt = STAT_UNDER;
              end else if ((in_ch.cmd == CMD_DIV) && (top_r == '0)) begin
                // divide by zero drops both operands
                ostat_nxt = STAT_DIVZ;
                count_nxt = count_r - CNT_W'(2);
                if (count_r >= CNT_W'(3)) begin
                  state_nxt = S_REFILL;
                end
              end else begin
                count_nxt = below_cnt;
                op_nxt    = in_ch.cmd;
                state_nxt = S_ALU;
              end
            end
            default: begin
            end
          endcase
          odepth_nxt = count_nxt;
        end
      end
      S_REFILL: begin
        top_nxt   = ram_rdata;
        state_nxt = S_IDLE;
      end
      S_ALU: begin
        state_nxt = S_IDLE;
        case (op_r)
          CMD_ADD: top_nxt = ram_rdata + top_r;
          CMD_SUB: top_nxt = ram_rdata - top_r;
          CMD_MUL: top_nxt = prod[DATA_W-1:0];
          CMD_DIV: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          top_nxt   = div_q;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r    <= top_nxt;
    op_r     <= op_nxt;
    oval_r   <= oval_nxt;
    ovld_r   <= ovld_nxt;
    ostat_r  <= ostat_nxt;
    odepth_r <= odepth_nxt;
  end

  // result word
  assign out_ch.valid     = ov_r;
  assign out_ch.out_value = oval_r;
  assign out_ch.out_valid = ovld_r;
  assign out_ch.status    = ostat_r;
  assign out_ch.depth     = odepth_r;

  // entries below the top
  smx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smx_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .a_i     (ram_rdata),
    .b_i     (top_r),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // stack count never passes the stack size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond stack size");

  // an accepted push on a non-full stack grows it by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !full && ((in_ch.cmd == CMD_PUSH) || (in_ch.cmd == CMD_IN)))
    |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not grow the stack");

  // refill and alu steps only run with a live top entry
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_REFILL) || (state_r == S_ALU)) |-> (count_r != '0))
    else $error("refill or alu step on an empty stack");

  // divider completes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  // a result word is produced for every accepted instruction
  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_ch.valid)
    else $error("accepted instruction left no result word");

endmodule

`default_nettype wire

// File: tb/stack_machine_execute_tb.sv
// stack_machine_execute_tb: self-checking testbench for the stack machine execution unit
// depends on smx_pkg, smx_in_if / smx_out_if and stack_machine_execute
`default_nettype none

// one expected or observed result word
typedef struct {
  logic [smx_pkg::DATA_W-1:0] value;
  logic                       out_valid;
  logic [smx_pkg::STAT_W-1:0] status;
  logic [smx_pkg::CNT_W-1:0]  depth;
} smx_result_t;

// shadow stack plus the queue of result words still owed by the block
class smx_result_tracker;
  logic [smx_pkg::DATA_W-1:0] stack_words [smx_pkg::STACK_DEPTH];
  int          stack_fill;
  smx_result_t pending_results [$];
  int          errors;
  int          n_instr;
  int          n_results;
  int          n_div;
  int          n_divz;
  int          n_under;
  int          n_over;

  function new();
    stack_fill = 0;
    errors     = 0;
    n_instr    = 0;
    n_results  = 0;
    n_div      = 0;
    n_divz     = 0;
    n_under    = 0;
    n_over     = 0;
  endfunction

  // signed division rounded toward zero, done on magnitudes so that
  // the most negative value over minus one wraps back to itself
  function logic [smx_pkg::DATA_W-1:0] quotient_toward_zero(
      input logic [smx_pkg::DATA_W-1:0] a, input logic [smx_pkg::DATA_W-1:0] b);
    logic                       neg_a;
    logic                       neg_b;
    logic [smx_pkg::DATA_W-1:0] mag_a;
    logic [smx_pkg::DATA_W-1:0] mag_b;
    logic [smx_pkg::DATA_W-1:0] q;
    neg_a = a[smx_pkg::DATA_W-1];
    neg_b = b[smx_pkg::DATA_W-1];
    mag_a = neg_a ? -a : a;
    mag_b = neg_b ? -b : b;
    q     = mag_a / mag_b;
    return (neg_a != neg_b) ? -q : q;
  endfunction

  // apply one accepted instruction to the shadow stack and queue its result
  function void note_instr(input logic [smx_pkg::CMD_W-1:0] cmd,
                           input logic [smx_pkg::DATA_W-1:0] operand);
    smx_result_t                exp_word;
    logic [smx_pkg::DATA_W-1:0] a;
    logic [smx_pkg::DATA_W-1:0] b;
    logic [smx_pkg::DATA_W-1:0] r;
    exp_word.value     = '0;
    exp_word.out_valid = 1'b0;
    exp_word.status    = smx_pkg::STAT_OK;
    case (cmd)
      smx_pkg::CMD_PUSH, smx_pkg::CMD_IN: begin
        if (stack_fill >= smx_pkg::STACK_DEPTH) begin
          exp_word.status = smx_pkg::STAT_OVER;
        end else begin
          stack_words[stack_fill] = operand;
          stack_fill++;
        end
      end
      smx_pkg::CMD_POP: begin
        if (stack_fill == 0) exp_word.status = smx_pkg::STAT_UNDER;
        else stack_fill--;
      end
      smx_pkg::CMD_OUT: begin
        if (stack_fill == 0) begin
          exp_word.status = smx_pkg::STAT_UNDER;
        end else begin
          stack_fill--;
          exp_word.value     = stack_words[stack_fill];
          exp_word.out_valid = 1'b1;
        end
      end
      smx_pkg::CMD_ADD, smx_pkg::CMD_SUB, smx_pkg::CMD_MUL, smx_pkg::CMD_DIV: begin
        if (cmd == smx_pkg::CMD_DIV) n_div++;
        if (stack_fill < 2) begin
          exp_word.status = smx_pkg::STAT_UNDER;
        end else begin
          b = stack_words[stack_fill-1];
          a = stack_words[stack_fill-2];
          stack_fill -= 2;
          if (cmd == smx_pkg::CMD_DIV && b == '0) begin
            // both operands gone, nothing pushed
            exp_word.status = smx_pkg::STAT_DIVZ;
          end else begin
            case (cmd)
              smx_pkg::CMD_ADD: r = a + b;
              smx_pkg::CMD_SUB: r = a - b;
              smx_pkg::CMD_MUL: r = a * b;
              default:          r = quotient_toward_zero(a, b);
            endcase
            stack_words[stack_fill] = r;
            stack_fill++;
          end
        end
      end
      default: begin
        // begin, end and unused codes leave the stack alone
      end
    endcase
    exp_word.depth = stack_fill[smx_pkg::CNT_W-1:0];
    case (exp_word.status)
      smx_pkg::STAT_UNDER: n_under++;
      smx_pkg::STAT_OVER:  n_over++;
      smx_pkg::STAT_DIVZ:  n_divz++;
      default: ;
    endcase
    n_instr++;
    pending_results.push_back(exp_word);
  endfunction

  task report_mismatch(input string what, input logic [smx_pkg::DATA_W-1:0] got,
                       input logic [smx_pkg::DATA_W-1:0] want);
    errors++;
    $display("mismatch %0d at result word %0d: %s got %h want %h",
             errors, n_results, what, got, want);
  endtask

  // compare one result word with the oldest one owed
  task check_result(input smx_result_t got);
    smx_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected word, depth", 32'(got.depth), '0);
    end else begin
      want = pending_results.pop_front();
      if (got.value !== want.value) report_mismatch("out_value", got.value, want.value);
      if (got.out_valid !== want.out_valid)
        report_mismatch("out_valid", 32'(got.out_valid), 32'(want.out_valid));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.depth !== want.depth)
        report_mismatch("depth", 32'(got.depth), 32'(want.depth));
    end
    n_results++;
  endtask
endclass

module stack_machine_execute_tb;
  import smx_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic idle_en = 1'b1;
  int   cycle_cnt = 0;

  smx_in_if  in_ch ();
  smx_out_if out_ch ();

  smx_result_tracker tracker = new();

  stack_machine_execute u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words owed", cycle_cnt,
               tracker.pending_results.size());
      $display("stack_machine_execute_tb NOT OK");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    smx_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.value     = out_ch.out_value;
      got.out_valid = out_ch.out_valid;
      got.status    = out_ch.status;
      got.depth     = out_ch.depth;
      tracker.check_result(got);
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12) * (($urandom_range(0, 7) == 0) ? 8 : 1)) @(posedge clk);
    end
  end

  // send one instruction word and wait for it to be taken
  task automatic send_instr(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] operand);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.operand <= operand;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    tracker.note_instr(cmd, operand);
  endtask

  // operand with a bias toward corner values and small numbers
  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = 32'd1;
          2: v = '1;
          3: v = {1'b1, {(DATA_W-1){1'b0}}};
          4: v = {1'b0, {(DATA_W-1){1'b1}}};
          default: v = 32'd2;
        endcase
      end
      1, 2: v = $urandom_range(0, 200) - 100;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // instruction mix that keeps the stack at a working depth
  function automatic logic [CMD_W-1:0] pick_cmd(input int fill);
    int r;
    int push_lim;
    logic [CMD_W-1:0] c;
    r = $urandom_range(0, 99);
    push_lim = (fill < 32) ? 40 : 22;
    if (r < 6) begin
      if ($urandom_range(0, 1) == 0)
        c = CMD_W'($urandom_range(int'(CMD_BEGIN), int'(CMD_END)));
      else c = CMD_W'($urandom_range(int'(CMD_IN) + 1, 2**CMD_W - 1));
    end else if (r < push_lim) begin
      c = ($urandom_range(0, 1) == 0) ? CMD_PUSH : CMD_IN;
    end else if (r < push_lim + 10) begin
      c = CMD_POP;
    end else if (r < push_lim + 22) begin
      c = CMD_OUT;
    end else begin
      c = CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_DIV)));
    end
    return c;
  endfunction

  // stimulus
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_BEGIN;
    in_ch.operand <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: underflow on empty and single-entry stack
    send_instr(CMD_OUT, 32'h1234_5678);
    send_instr(CMD_POP, '0);
    send_instr(CMD_ADD, '0);
    send_instr(CMD_PUSH, 32'h7fff_ffff);
    send_instr(CMD_MUL, '0);
    // add wraps past the most positive value
    send_instr(CMD_PUSH, 32'd1);
    send_instr(CMD_ADD, '0);
    // most negative over minus one
    send_instr(CMD_IN, 32'hffff_ffff);
    send_instr(CMD_DIV, '0);
    send_instr(CMD_OUT, '0);
    // division rounds toward zero
    send_instr(CMD_PUSH, 32'd7);
    send_instr(CMD_IN, -32'sd2);
    send_instr(CMD_DIV, '0);
    // divide by zero drops both operands
    send_instr(CMD_PUSH, '0);
    send_instr(CMD_DIV, '0);
    send_instr(CMD_PUSH, 32'd5);
    send_instr(CMD_PUSH, 32'd9);
    send_instr(CMD_SUB, '0);
    send_instr(CMD_PUSH, -32'sd3);
    send_instr(CMD_MUL, '0);
    // no-ops and unused codes
    send_instr(CMD_BEGIN, 32'hdead_beef);
    send_instr(CMD_END, 32'hffff_ffff);
    send_instr(CMD_W'(CMD_IN + 1), '1);
    send_instr(CMD_W'(2**CMD_W - 1), '1);
    send_instr(CMD_OUT, '0);

    // random mix at working depth
    repeat (30) send_instr(pick_cmd(tracker.stack_fill), pick_operand());

    // fill to the top, push past it, then knock one off and refill
    while (tracker.stack_fill < STACK_DEPTH)
      send_instr(($urandom_range(0, 3) == 0) ? CMD_IN : CMD_PUSH, pick_operand());
    send_instr(CMD_PUSH, pick_operand());
    send_instr(CMD_IN, pick_operand());
    send_instr(CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_DIV))), '0);
    while (tracker.stack_fill < STACK_DEPTH) send_instr(CMD_IN, pick_operand());
    send_instr(CMD_PUSH, pick_operand());

    // drain from full with results and arithmetic mixed in
    while (tracker.stack_fill > 0) begin
      case ($urandom_range(0, 9))
        0:       send_instr(CMD_POP, pick_operand());
        1, 2, 3: send_instr(CMD_OUT, pick_operand());
        4:       send_instr(pick_cmd(tracker.stack_fill), pick_operand());
        default: send_instr(CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_DIV))),
                            pick_operand());
      endcase
    end
    send_instr(CMD_OUT, '0);

    // last stretch at full rate
    idle_en <= 1'b0;
    repeat (30) send_instr(pick_cmd(tracker.stack_fill), pick_operand());
    in_ch.valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d instructions, checked %0d result words in %0d cycles",
             tracker.n_instr, tracker.n_results, cycle_cnt);
    $display("seen %0d divides, %0d divide by zero, %0d underflow, %0d overflow cases",
             tracker.n_div, tracker.n_divz, tracker.n_under, tracker.n_over);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("stack_machine_execute_tb OK");
    end else begin
      $display("stack_machine_execute_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
